// File: design/page_frame_clock_translator_macros.svh
// Assertion macros shared by the page frame translator RTL
`ifndef PAGE_FRAME_CLOCK_TRANSLATOR_MACROS_SVH
`define PAGE_FRAME_CLOCK_TRANSLATOR_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define PFCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define PFCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pfct_pkg.sv
// Shared types and constants for the page frame translator
`default_nettype none

package pfct_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

  localparam int PAGE_W  = 20;
  localparam int OFF_W   = 20;
  localparam int ADDR_W  = 26;
  localparam int FOUT_W  = 6;
  localparam int FAULT_W = 32;
  localparam int FIU_W   = 7;
  localparam int OBITS_W = 5;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS   = 1'd1;

  localparam logic [FIU_W-1:0]   FIU_RESET   = 7'd64;
  localparam logic [OBITS_W-1:0] OBITS_RESET = 5'd12;

  // match search groups
  localparam int GRP   = 8;
  localparam int GRP_W = 3;
  localparam int NGRP  = (MAX_FRAMES + GRP - 1) / GRP;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_FIND1,
    S_FIND2,
    S_DECIDE,
    S_WALK,
    S_DONE
  } state_t;

  // command broadcast to every cell
  typedef struct packed {
    logic               cmp;
    logic               load;
    logic               set_ref;
    logic               use_tok;
    logic               step;
    logic               home;
    logic [FRAME_W-1:0] wr_idx;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: design/page_frame_clock_translator.sv
// A hit, or a miss with a never-used frame, passes the states compare, find1, find2, decide and done.
// A miss with no never-used frame left walks the clock hand, clearing reference bits, until a frame is not referenced.
// A new beat is accepted only in idle, once the last result has been placed in the output register.
// Reset (synchronous, active high) clears valid and reference bits, hand and counters,
// and returns the config registers to their defaults.
// Page tags are not cleared; no clearing pass is run.
`default_nettype none

module page_frame_clock_translator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [pfct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfct_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pfct_pkg::PAGE_W-1:0]      page_number,
  input  logic [pfct_pkg::OFF_W-1:0]       offset,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pfct_pkg::ADDR_W-1:0]      physical_address,
  output logic                             hit,
  output logic [pfct_pkg::FOUT_W-1:0]      frame_used,
  output logic [pfct_pkg::FAULT_W-1:0]     fault_total
);
  import pfct_pkg::*;

  `include "page_frame_clock_translator_macros.svh"

  state_t              state;
  state_t              state_next;
  cell_cmd_t           cmd;

  logic [FIU_W-1:0]    frames_in_use;
  logic [OBITS_W-1:0]  offset_bits;
  logic [CNT_W-1:0]    n;

  logic [PAGE_W-1:0]   q_page;
  logic [OFF_W-1:0]    q_off;
  logic [FRAME_W-1:0]  hand;
  logic [FRAME_W-1:0]  hand_inc;
  logic [CNT_W-1:0]    next_free;
  logic [FAULT_W-1:0]  fault_count;
  logic [FAULT_W-1:0]  fault_inc;

  logic [FRAME_W-1:0]  res_frame;
  logic                res_hit;
  logic [FAULT_W-1:0]  res_fault;

  logic [MAX_FRAMES-1:0] tok_vec;
  logic [MAX_FRAMES-1:0] tok_chain;
  logic [MAX_FRAMES-1:0] match_vec;
  logic [MAX_FRAMES-1:0] vr_vec;
  logic [MAX_FRAMES-1:0] last_mask;
  logic                  wrap_tok;
  logic                  vr_tok;

  logic                  f_hit;
  logic [FRAME_W-1:0]    f_frame;
  logic                  out_free;
  logic [ADDR_W-1:0]     addr_shift;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FIU_RESET;
      offset_bits   <= OBITS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAMES_IN_USE: frames_in_use <= cfg_data[FIU_W-1:0];
        REG_OFFSET_BITS:   offset_bits   <= cfg_data[OBITS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the managed frame count to 1..MAX_FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      n = CNT_W'(1);
    end else if (32'(frames_in_use) > MAX_FRAMES) begin
      n = CNT_W'(MAX_FRAMES);
    end else begin
      n = CNT_W'(frames_in_use);
    end
  end

  assign hand_inc  = (CNT_W'(hand) + CNT_W'(1) >= n) ? '0 : hand + FRAME_W'(1);
  assign fault_inc = (fault_count == '1) ? fault_count : fault_count + FAULT_W'(1);

  // token wraps from the last managed frame back to frame 0
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      last_mask[i] = (CNT_W'(i) + CNT_W'(1) == n);
    end
  end

  assign wrap_tok = |(tok_vec & last_mask);
  assign vr_tok   = |(tok_vec & vr_vec);

  // row of frame cells, token handed from each cell to the next
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_chain[i] = wrap_tok;
    end else begin : g_body
      assign tok_chain[i] = tok_vec[i-1];
    end

    pfct_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .idx    (FRAME_W'(i)),
      .n      (n),
      .q_page (q_page),
      .cmd    (cmd),
      .tok_in (tok_chain[i]),
      .tok    (tok_vec[i]),
      .match  (match_vec[i]),
      .vr     (vr_vec[i])
    );
  end

  pfct_find u_find (
    .clk       (clk),
    .rst       (rst),
    .match_vec (match_vec),
    .f_hit     (f_hit),
    .f_frame   (f_frame)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // next state and cell commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_FIND1;
      end
      S_FIND1: state_next = S_FIND2;
      S_FIND2: state_next = S_DECIDE;
      S_DECIDE: begin
        if (f_hit) begin
          cmd.set_ref = 1'b1;
          cmd.wr_idx  = f_frame;
          state_next  = S_DONE;
        end else if (next_free < n) begin
          cmd.load   = 1'b1;
          cmd.wr_idx = next_free[FRAME_W-1:0];
          state_next = S_DONE;
        end else begin
          cmd.home   = (CNT_W'(hand) >= n);
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.step    = 1'b1;
        cmd.use_tok = 1'b1;
        cmd.load    = !vr_tok;
        if (!vr_tok) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_page <= page_number;
      q_off  <= offset;
    end
  end

  // advance the hand, free count and fault counter
  always_ff @(posedge clk) begin
    if (rst) begin
      hand        <= '0;
      next_free   <= '0;
      fault_count <= '0;
    end else begin
      if (state == S_DECIDE && !f_hit) begin
        fault_count <= fault_inc;
        if (next_free < n) begin
          next_free <= next_free + CNT_W'(1);
        end else if (CNT_W'(hand) >= n) begin
          hand <= '0;
        end
      end
      if (state == S_WALK) begin
        hand <= hand_inc;
      end
    end
  end

  // hold the result until the output slot is free
  always_ff @(posedge clk) begin
    if (state == S_DECIDE) begin
      res_hit <= f_hit;
      if (f_hit) begin
        res_frame <= f_frame;
        res_fault <= fault_count;
      end else begin
        res_frame <= next_free[FRAME_W-1:0];
        res_fault <= fault_inc;
      end
    end else if (state == S_WALK && !vr_tok) begin
      res_frame <= hand;
    end
  end

  assign addr_shift = ADDR_W'(res_frame) << offset_bits;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      physical_address <= addr_shift | ADDR_W'(q_off);
      hit              <= res_hit;
      frame_used       <= FOUT_W'(res_frame);
      fault_total      <= res_fault;
    end
  end

  `PFCT_ASSERT_SAME(a_tok_onehot, 1'b1, $onehot(tok_vec), "hand token is not one-hot")
  `PFCT_ASSERT_SAME(a_hand_tok, state == S_WALK, tok_vec[hand],
                    "hand counter and token disagree during the walk")
  `PFCT_ASSERT_SAME(a_free_bound, 1'b1, 32'(next_free) <= MAX_FRAMES,
                    "free frame count beyond frame table")
  `PFCT_ASSERT_NEXT(a_fault_mono, 1'b1, $past(rst) || fault_count >= $past(fault_count),
                    "fault counter went down")

endmodule

`default_nettype wire

// File: design/pfct_cell.sv
// One frame cell: page tag, valid and reference bits, clock hand token
`default_nettype none

module pfct_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [pfct_pkg::FRAME_W-1:0] idx,
  input  logic [pfct_pkg::CNT_W-1:0]   n,
  input  logic [pfct_pkg::PAGE_W-1:0]  q_page,
  input  pfct_pkg::cell_cmd_t          cmd,
  input  logic                      tok_in,
  output logic                      tok,
  output logic                      match,
  output logic                      vr
);
  import pfct_pkg::*;

  logic [PAGE_W-1:0] page;
  logic              valid;
  logic              refd;
  logic              in_range;
  logic              sel;

  assign in_range = CNT_W'(idx) < n;
  assign sel      = cmd.use_tok ? tok : (cmd.wr_idx == idx);
  assign vr       = valid & refd;

  // hold the page tag; written only on load
  always_ff @(posedge clk) begin
    if (cmd.load && sel) begin
      page <= q_page;
    end
  end

  // update valid, reference, token and match flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      refd  <= 1'b0;
      tok   <= (idx == '0);
      match <= 1'b0;
    end else begin
      if (cmd.load && sel) begin
        valid <= 1'b1;
        refd  <= 1'b1;
      end else if (cmd.set_ref && sel) begin
        refd <= 1'b1;
      end else if (cmd.step && tok && valid && refd) begin
        refd <= 1'b0;
      end
      if (cmd.home) begin
        tok <= (idx == '0);
      end else if (cmd.step) begin
        tok <= in_range & tok_in;
      end
      if (cmd.cmp) begin
        match <= valid & (page == q_page) & in_range;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/pfct_find.sv
// Two-stage registered priority search for the lowest matching frame
`default_nettype none

module pfct_find (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [pfct_pkg::MAX_FRAMES-1:0] match_vec,
  output logic                           f_hit,
  output logic [pfct_pkg::FRAME_W-1:0]    f_frame
);
  import pfct_pkg::*;

  localparam int PAD_W = NGRP * GRP;

  logic [PAD_W-1:0]  padded;
  logic [NGRP-1:0]   g_any;
  logic [GRP_W-1:0]  g_low [NGRP];
  logic [NGRP-1:0]   g_any_next;
  logic [GRP_W-1:0]  g_low_next [NGRP];
  logic              hit_next;
  logic [FRAME_W-1:0] frame_next;

  assign padded = PAD_W'(match_vec);

  // stage one: lowest set bit inside each group of eight
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      g_any_next[g] = |padded[g*GRP +: GRP];
      g_low_next[g] = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
        if (padded[g*GRP + b]) begin
          g_low_next[g] = GRP_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_any <= '0;
    end else begin
      g_any <= g_any_next;
    end
  end

  always_ff @(posedge clk) begin
    g_low <= g_low_next;
  end

  // stage two: lowest group with a match
  always_comb begin
    hit_next   = 1'b0;
    frame_next = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (g_any[g]) begin
        hit_next   = 1'b1;
        frame_next = FRAME_W'(g * GRP + int'(g_low[g]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_hit <= 1'b0;
    end else begin
      f_hit <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    f_frame <= frame_next;
  end

endmodule

`default_nettype wire

// File: dv/pfct_translation_check.sv
// Checker for the page frame translator: predicts each translation and compares result beats
module pfct_translation_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pfct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfct_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [pfct_pkg::PAGE_W-1:0]    page_number,
  input  logic [pfct_pkg::OFF_W-1:0]     offset,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [pfct_pkg::ADDR_W-1:0]    physical_address,
  input  logic                           hit,
  input  logic [pfct_pkg::FOUT_W-1:0]    frame_used,
  input  logic [pfct_pkg::FAULT_W-1:0]   fault_total,
  output int                             mismatch_count,
  output int                             pending_translations
);
  import pfct_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic               hit;
    logic [FOUT_W-1:0]  frame;
    logic [FAULT_W-1:0] faults;
  } translation_t;

  translation_t       expected_translations[$];

  // shadow of the frame table and the replacement state
  logic [PAGE_W-1:0]  tag_store  [MAX_FRAMES];
  logic               resident   [MAX_FRAMES];
  logic               referenced [MAX_FRAMES];
  logic [FRAME_W-1:0] hand;
  logic [CNT_W-1:0]   next_unused;
  logic [FAULT_W-1:0] fault_count;
  logic [FIU_W-1:0]   frames_reg;
  logic [OBITS_W-1:0] shift_reg;

  // Look up one page, update the table and return the translation it yields
  task automatic translate_page(input logic [PAGE_W-1:0] page, input logic [OFF_W-1:0] off,
                                output translation_t res);
    int          n;
    int          frame;
    int          h;
    bit          found;
    bit          placed;
    logic [63:0] wide;
    n = frames_reg;
    if (n == 0) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    found = 1'b0;
    frame = 0;
    // search only the frames currently managed
    for (int i = 0; i < n; i++) begin
      if (!found && resident[i] && tag_store[i] == page) begin
        found = 1'b1;
        frame = i;
      end
    end
    if (found) begin
      referenced[frame] = 1'b1;
    end else begin
      if (fault_count != '1) fault_count++;
      if (next_unused < n) begin
        frame = next_unused;
        next_unused++;
      end else begin
        // second chance: clear set bits, stop at the first clear or empty frame
        if (hand >= n) hand = '0;
        placed = 1'b0;
        for (int s = 0; s < 2 * n + 1; s++) begin
          if (!placed) begin
            h = hand;
            hand = (h + 1 >= n) ? '0 : FRAME_W'(h + 1);
            if (resident[h] && referenced[h]) begin
              referenced[h] = 1'b0;
            end else begin
              frame = h;
              placed = 1'b1;
            end
          end
        end
      end
      tag_store[frame]  = page;
      resident[frame]   = 1'b1;
      referenced[frame] = 1'b1;
    end
    wide = (64'(frame) << shift_reg) | 64'(off);
    res.addr   = wide[ADDR_W-1:0];
    res.hit    = found;
    res.frame  = FOUT_W'(frame);
    res.faults = fault_count;
  endtask

  // Track config writes, predict on input beats, compare on result beats
  always @(posedge clk) begin : watch
    translation_t got;
    translation_t want;
    if (rst) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        tag_store[i]  = '0;
        resident[i]   = 1'b0;
        referenced[i] = 1'b0;
      end
      hand        = '0;
      next_unused = '0;
      fault_count = '0;
      frames_reg  = FIU_RESET;
      shift_reg   = OBITS_RESET;
      expected_translations.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_FRAMES_IN_USE) frames_reg = cfg_data[FIU_W-1:0];
        else if (cfg_index == REG_OFFSET_BITS) shift_reg = cfg_data[OBITS_W-1:0];
      end
      if (out_valid && out_ready) begin
        got = '{physical_address, hit, frame_used, fault_total};
        if (expected_translations.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: addr=%h hit=%b frame=%0d faults=%0d",
                     got.addr, got.hit, got.frame, got.faults);
        end else begin
          want = expected_translations.pop_front();
          if (got.addr !== want.addr || got.hit !== want.hit ||
              got.frame !== want.frame || got.faults !== want.faults) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp addr=%h hit=%b frame=%0d faults=%0d | got addr=%h hit=%b frame=%0d faults=%0d",
                       want.addr, want.hit, want.frame, want.faults,
                       got.addr, got.hit, got.frame, got.faults);
          end
        end
      end
      if (in_valid && in_ready) begin
        translate_page(page_number, offset, want);
        expected_translations.push_back(want);
      end
    end
    pending_translations = expected_translations.size();
  end

endmodule

// File: dv/page_frame_clock_translator_tb.sv
// Testbench top for the page frame translator: stimulus, flow control and verdict
module page_frame_clock_translator_tb;
  import pfct_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PAGE_W-1:0]    page_number = '0;
  logic [OFF_W-1:0]     offset = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ADDR_W-1:0]    physical_address;
  logic                 hit;
  logic [FOUT_W-1:0]    frame_used;
  logic [FAULT_W-1:0]   fault_total;
  int                   mismatch_count;
  int                   pending_translations;

  // stimulus controls shared with the result side
  bit                   calm = 1'b0;
  bit                   hold_req = 1'b0;
  bit                   hold_done = 1'b0;
  int                   active_n = MAX_FRAMES;
  logic [PAGE_W-1:0]    pool_base = '0;
  int                   pool_span = 1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  page_frame_clock_translator dut (.*);

  pfct_translation_check checker_i (.*);

  // Result side: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      repeat (400) @(negedge clk);
      out_ready <= 1'b1;
      hold_done = 1'b1;
    end else if (calm || $urandom_range(0, 99) >= 33) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
    end
  end

  // Offer one beat, with an occasional gap ahead of it, and hold until accepted
  task automatic send_beat(input logic [PAGE_W-1:0] p, input logic [OFF_W-1:0] o);
    if (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    page_number <= p;
    offset      <= o;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Draw a page mostly from the current working set so hits and evictions both occur
  task automatic send_random();
    logic [PAGE_W-1:0] p;
    logic [OFF_W-1:0]  o;
    if ($urandom_range(0, 99) < 75) p = pool_base + PAGE_W'($urandom_range(0, pool_span - 1));
    else p = PAGE_W'($urandom);
    case ($urandom_range(0, 3))
      0: o = OFF_W'($urandom_range(0, 255));
      1: o = ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: o = OFF_W'($urandom);
    endcase
    send_beat(p, o);
  endtask

  // Stop offering and wait until every translation has come back
  task automatic wait_results(input int tail);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_translations != 0);
    repeat (tail) @(negedge clk);
  endtask

  // Write both registers back to back while the block is idle
  task automatic program_regs(input int fiu, input int obits);
    cfg_write <= 1'b1;
    cfg_index <= REG_FRAMES_IN_USE;
    cfg_data  <= CFG_W'(fiu);
    @(negedge clk);
    cfg_index <= REG_OFFSET_BITS;
    cfg_data  <= CFG_W'(obits);
    @(negedge clk);
    cfg_write <= 1'b0;
    active_n  = (fiu == 0) ? 1 : (fiu > MAX_FRAMES) ? MAX_FRAMES : fiu;
    pool_base = PAGE_W'($urandom);
    pool_span = $urandom_range(1, 2 * active_n + 2);
  endtask

  // Main stimulus
  initial begin
    int fiu;
    int obits;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: field extremes, hits on resident pages
    send_beat('0, '0);
    send_beat('1, '1);
    send_beat('0, 20'h00ABC);
    send_beat('1, '0);
    send_beat(20'h00001, 20'h00FFF);

    // two frames: out-of-range resident frame, clock walk, wide offset
    wait_results(8);
    program_regs(2, 20);
    send_beat(20'h00001, '0);
    send_beat(20'h00002, 20'h00001);
    send_beat(20'h00001, 20'h00002);
    send_beat(20'h00002, 20'h00003);
    send_beat(20'h00003, '1);

    // zero frames act as one, shift past the address width
    wait_results(8);
    program_regs(0, 31);
    send_beat(20'h00008, '0);
    send_beat(20'h00008, 20'h12345);
    send_beat(20'h00009, 20'h80000);

    // single frame with a small shift
    wait_results(8);
    program_regs(1, 5);
    send_beat(20'h00003, '0);
    send_beat(20'h00004, '0);
    send_beat(20'h00003, 20'h00007);

    // oversized frame count saturates, no shift
    wait_results(8);
    program_regs(127, 0);
    send_beat(20'h00009, '1);
    send_beat(20'h55555, 20'hAAAAA);
    send_beat(20'hAAAAA, 20'h55555);
    send_beat('0, '0);

    // random phases, each with its own settings and working set
    for (int ph = 0; ph < 14; ph++) begin
      wait_results(8);
      case ($urandom_range(0, 5))
        0: fiu = 0;
        1: fiu = 1;
        2: fiu = MAX_FRAMES;
        3: fiu = 127;
        default: fiu = $urandom_range(2, 16);
      endcase
      case ($urandom_range(0, 4))
        0: obits = 0;
        1: obits = 20;
        2: obits = 31;
        default: obits = $urandom_range(0, 31);
      endcase
      if (ph == 0) begin
        fiu   = 4;
        obits = 12;
      end
      program_regs(fiu, obits);
      calm <= (ph == 3);
      for (int k = 0; k < 100; k++) begin
        if (ph == 5 && k == 10) hold_req <= 1'b1;
        if (ph == 8 && k == 50) wait_results(0);
        send_random();
      end
    end

    wait_results(20);
    if (mismatch_count == 0 && pending_translations == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
